### design/obis_pkg.sv
package obis_pkg;

  // Sizes
  localparam int NQ  = 30;
  localparam int WIN = 13;
  localparam int QW  = $clog2(NQ);

  // Number of leading quantities that are totals of energy (scaled by ten)
  localparam int NTOTAL = 4;

  // Frame framing constants
  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] FORMAT_TYPE = 8'hA0;
  localparam logic [7:0] HI_NIBBLE   = 8'hF0;
  localparam logic [7:0] LO_NIBBLE   = 8'h0F;

  // OBIS tag bytes: 09 06 01 01 C D 00 FF
  localparam logic [7:0] TAG_STRUCT = 8'h09;
  localparam logic [7:0] TAG_LEN    = 8'h06;
  localparam logic [7:0] TAG_A      = 8'h01;
  localparam logic [7:0] TAG_B      = 8'h01;
  localparam logic [7:0] TAG_E      = 8'h00;
  localparam logic [7:0] TAG_F      = 8'hFF;

  // Date marker FF 80 00 00
  localparam logic [7:0] MARK_0 = 8'hFF;
  localparam logic [7:0] MARK_1 = 8'h80;
  localparam logic [7:0] MARK_2 = 8'h00;
  localparam logic [7:0] MARK_3 = 8'h00;

  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  // Per-quantity OBIS C and D codes
  localparam logic [7:0] CODE_C [NQ] = '{
    8'd1,  8'd2,  8'd3,  8'd4,  8'd1,  8'd2,  8'd3,  8'd4,  8'd32, 8'd52,
    8'd72, 8'd31, 8'd51, 8'd71, 8'd21, 8'd41, 8'd61, 8'd33, 8'd53, 8'd73,
    8'd13, 8'd22, 8'd42, 8'd62, 8'd22, 8'd42, 8'd62, 8'd21, 8'd41, 8'd61};
  localparam logic [7:0] CODE_D [NQ] = '{
    8'd8, 8'd8, 8'd8, 8'd8, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7,
    8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7,
    8'd7, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8};
  // 1: four-byte value, 0: two-byte value
  localparam logic VAL_LONG [NQ] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

  // Frame summary handed from the scanner to the result stage
  typedef struct packed {
    logic        frame_ok;
    logic [3:0]  list_id;
    logic [11:0] message_size;
    logic [11:0] byte_count;
  } frame_info_t;

endpackage

### design/obis_meter_frame_value_extractor.sv
// A frame's last byte is registered, then its summary and the emit state,
// then each result in the output register. One frame byte per cycle while
// in_tready is high: the byte is registered and the 13-byte window compare
// against all tags runs in the following cycle. After the last byte, input
// waits until all 30 results are loaded; out_tready high drains one per cycle.
// Synchronous reset (rst_n low) clears per-frame, emit and output valid state.
module obis_meter_frame_value_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] quantity, [36:5] reading, [37] reading_valid, [41:38] list_id,
  // [53:42] message_size, [65:54] byte_count, [66] frame_ok, [71:67] zero
  output logic [71:0] out_tdata,
  output logic        out_tlast   // last_result
);
  import obis_pkg::*;

  logic          emit_busy;
  logic          frame_clear;
  logic          frame_end;
  logic [QW-1:0] rd_idx;
  logic [31:0]   rd_value;
  logic          rd_found;
  frame_info_t   info;

  obis_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .emit_busy  (emit_busy),
    .frame_clear(frame_clear),
    .rd_idx     (rd_idx),
    .rd_value   (rd_value),
    .rd_found   (rd_found),
    .info       (info),
    .frame_end  (frame_end)
  );

  obis_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_end  (frame_end),
    .info       (info),
    .rd_value   (rd_value),
    .rd_found   (rd_found),
    .rd_idx     (rd_idx),
    .busy       (emit_busy),
    .frame_clear(frame_clear),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

### design/obis_scan.sv
module obis_scan (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [7:0]              in_byte,
  input  logic                    in_last,
  output logic                    in_ready,
  input  logic                    emit_busy,
  input  logic                    frame_clear,
  input  logic [obis_pkg::QW-1:0] rd_idx,
  output logic [31:0]             rd_value,
  output logic                    rd_found,
  output obis_pkg::frame_info_t   info,
  output logic                    frame_end
);
  import obis_pkg::*;

  logic [7:0]  byte_r;
  logic        last_r;
  logic        vld_r;
  logic        vld_nxt;

  logic [7:0]  win_r   [WIN];
  logic [7:0]  win_nxt [WIN];
  logic [7:0]  hdr_r   [3];
  logic [7:0]  hdr_nxt [3];
  logic [11:0] count_r;
  logic [11:0] count_nxt;
  logic        mark_r;
  logic        mark_nxt;
  logic [3:0]  nib_r;
  logic [3:0]  nib_nxt;
  logic [NQ-1:0] found_r;
  logic [NQ-1:0] found_nxt;
  logic [NQ-1:0] cap_we;
  logic [31:0]   cap_r [NQ];
  frame_info_t info_r;
  frame_info_t info_nxt;

  logic        pre_long;
  logic        pre_short;
  logic [31:0] val_long;
  logic [31:0] val_short;

  // Input register; no new byte while the frame's results go out
  assign in_ready = !emit_busy && !(vld_r && last_r);
  assign vld_nxt  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_nxt) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  // Window shift with the registered byte
  always_comb begin
    for (int i = 0; i < WIN - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[WIN-1] = byte_r;
  end

  // Fixed tag bytes at both offsets; value bytes sit at the window end
  assign pre_long  = win_nxt[0] == TAG_STRUCT && win_nxt[1] == TAG_LEN &&
                     win_nxt[2] == TAG_A && win_nxt[3] == TAG_B &&
                     win_nxt[6] == TAG_E && win_nxt[7] == TAG_F;
  assign pre_short = win_nxt[2] == TAG_STRUCT && win_nxt[3] == TAG_LEN &&
                     win_nxt[4] == TAG_A && win_nxt[5] == TAG_B &&
                     win_nxt[8] == TAG_E && win_nxt[9] == TAG_F;
  assign val_long  = {win_nxt[9], win_nxt[10], win_nxt[11], win_nxt[12]};
  assign val_short = {16'h0000, win_nxt[11], win_nxt[12]};

  // Per-quantity match: first occurrence only
  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      if (VAL_LONG[q]) begin
        cap_we[q] = vld_r && !found_r[q] && pre_long &&
                    win_nxt[4] == CODE_C[q] && win_nxt[5] == CODE_D[q];
      end else begin
        cap_we[q] = vld_r && !found_r[q] && pre_short &&
                    win_nxt[6] == CODE_C[q] && win_nxt[7] == CODE_D[q];
      end
    end
    found_nxt = found_r | cap_we;
  end

  // Header bytes, byte count, date marker
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    if (count_r < 12'd3) begin
      hdr_nxt[count_r[1:0]] = byte_r;
    end
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 12'd1;
    mark_nxt  = mark_r;
    nib_nxt   = nib_r;
    if (!mark_r && win_nxt[7] == MARK_0 && win_nxt[8] == MARK_1 &&
        win_nxt[9] == MARK_2 && win_nxt[10] == MARK_3) begin
      mark_nxt = 1'b1;
      nib_nxt  = 4'((win_nxt[12] & HI_NIBBLE) >> 4);
    end
  end

  // Frame summary taken on the last byte
  always_comb begin
    info_nxt.frame_ok     = hdr_nxt[0] == FLAG_BYTE && byte_r == FLAG_BYTE &&
                            (hdr_nxt[1] & HI_NIBBLE) == FORMAT_TYPE;
    info_nxt.list_id      = nib_nxt;
    info_nxt.message_size = {4'(hdr_nxt[1] & LO_NIBBLE), hdr_nxt[2]};
    info_nxt.byte_count   = count_nxt;
  end

  // Per-frame state
  always_ff @(posedge clk) begin
    if (!rst_n || frame_clear) begin
      for (int i = 0; i < WIN; i++) begin
        win_r[i] <= 8'h00;
      end
      for (int i = 0; i < 3; i++) begin
        hdr_r[i] <= 8'h00;
      end
      count_r <= 12'd0;
      mark_r  <= 1'b0;
      nib_r   <= 4'd0;
      found_r <= '0;
    end else if (vld_r) begin
      win_r   <= win_nxt;
      hdr_r   <= hdr_nxt;
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
      nib_r   <= nib_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r && last_r) begin
      info_r <= info_nxt;
    end
  end

  // Captured values; only read where the found flag is set
  always_ff @(posedge clk) begin
    for (int q = 0; q < NQ; q++) begin
      if (cap_we[q]) begin
        cap_r[q] <= VAL_LONG[q] ? val_long : val_short;
      end
    end
  end

  assign frame_end = vld_r && last_r;
  assign info      = info_r;
  assign rd_value  = cap_r[rd_idx];
  assign rd_found  = found_r[rd_idx];

endmodule

### design/obis_emit.sv
module obis_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    frame_end,
  input  obis_pkg::frame_info_t   info,
  input  logic [31:0]             rd_value,
  input  logic                    rd_found,
  output logic [obis_pkg::QW-1:0] rd_idx,
  output logic                    busy,
  output logic                    frame_clear,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [71:0]             out_data,
  output logic                    out_last
);
  import obis_pkg::*;

  logic          busy_r;
  logic [QW-1:0] idx_r;
  logic          load;
  logic          valid_q;
  logic [31:0]   value_q;
  logic          ovld_r;
  logic [71:0]   odata_r;
  logic          olast_r;

  // A result moves into the output register when it is empty or drained
  assign load        = busy_r && (!ovld_r || out_ready);
  assign frame_clear = load && idx_r == QW'(NQ - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (frame_end) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= !frame_clear;
      idx_r  <= idx_r + QW'(1);
    end
  end

  // Result value: totals of energy scaled by ten, zero when invalid
  always_comb begin
    valid_q = info.frame_ok && rd_found;
    value_q = 32'h0;
    if (valid_q) begin
      if (idx_r < QW'(NTOTAL)) begin
        value_q = (rd_value << 3) + (rd_value << 1);
      end else begin
        value_q = rd_value;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (load) begin
      ovld_r <= 1'b1;
    end else if (out_ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      odata_r <= {5'b00000, info.frame_ok, info.byte_count, info.message_size,
                  info.list_id, valid_q, value_q, idx_r};
      olast_r <= idx_r == QW'(NQ - 1);
    end
  end

  assign rd_idx    = idx_r;
  assign busy      = busy_r;
  assign out_valid = ovld_r;
  assign out_data  = odata_r;
  assign out_last  = olast_r;

endmodule

### bench/obis_meter_frame_value_extractor_tb.sv
module obis_meter_frame_value_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obis_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BYTES = 120;

  // One input transaction: a frame byte and its end-of-frame mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // One result transaction, fields in the order of out_tdata
  typedef struct packed {
    logic [4:0]  quantity;
    logic [31:0] reading;
    logic        reading_valid;
    logic [3:0]  list_id;
    logic [11:0] message_size;
    logic [11:0] byte_count;
    logic        frame_ok;
    logic        last_result;
  } meter_reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] frame_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [4:0] quantity, [36:5] reading, [37] reading_valid, [41:38] list_id,
  // [53:42] message_size, [65:54] byte_count, [66] frame_ok, [71:67] zero
  logic [71:0] out_tdata;
  logic        out_tlast;        // last_result

  obis_meter_frame_value_extractor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  frame_byte_t    bytes_pending[$];
  meter_reading_t readings_due[$];
  logic [7:0]     frame_buf[$];

  int n_errors  = 0;
  int n_frames  = 0;
  int n_bytes   = 0;
  int n_checked = 0;
  int n_valid   = 0;
  int cycles    = 0;

  // Per-frame state of the expected-value tracker
  logic [7:0]  win_bytes [WIN];
  logic [31:0] tag_value [NQ];
  logic        tag_seen  [NQ];
  logic [7:0]  hdr_bytes [3];
  logic        marker_seen;
  logic [3:0]  list_nib;
  logic [11:0] frame_len;

  task automatic note_error(input string msg);
    n_errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input int idx,
                           input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      note_error($sformatf("result %0d: %s got 0x%0h, expected 0x%0h",
                           idx, name, got, want));
  endtask

  task automatic clear_frame_state();
    for (int i = 0; i < WIN; i++) win_bytes[i] = 8'h00;
    for (int q = 0; q < NQ; q++) begin
      tag_value[q] = 32'h0;
      tag_seen[q]  = 1'b0;
    end
    for (int i = 0; i < 3; i++) hdr_bytes[i] = 8'h00;
    marker_seen = 1'b0;
    list_nib    = 4'h0;
    frame_len   = 12'h000;
  endtask

  // Track one accepted byte; on the frame's last byte queue all 30 readings
  task automatic scan_meter_byte(input logic [7:0] b, input logic last);
    int             o;
    logic [31:0]    v;
    logic           ok;
    logic [11:0]    msize;
    meter_reading_t r;
    if (frame_len < 3) hdr_bytes[frame_len] = b;
    if (frame_len != COUNT_MAX) frame_len++;
    for (int i = 0; i < WIN - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[WIN - 1] = b;

    // first date marker sets the list id
    if (!marker_seen && win_bytes[7] == MARK_0 && win_bytes[8] == MARK_1 &&
        win_bytes[9] == MARK_2 && win_bytes[10] == MARK_3) begin
      marker_seen = 1'b1;
      list_nib    = win_bytes[12][7:4];
    end

    // tag at the window head, or two bytes later for two-byte values
    for (int q = 0; q < NQ; q++) begin
      o = VAL_LONG[q] ? 0 : 2;
      if (!tag_seen[q] && win_bytes[o] == TAG_STRUCT && win_bytes[o + 1] == TAG_LEN &&
          win_bytes[o + 2] == TAG_A && win_bytes[o + 3] == TAG_B &&
          win_bytes[o + 4] == CODE_C[q] && win_bytes[o + 5] == CODE_D[q] &&
          win_bytes[o + 6] == TAG_E && win_bytes[o + 7] == TAG_F) begin
        v = 32'h0;
        for (int k = o + 9; k < WIN; k++) v = {v[23:0], win_bytes[k]};
        tag_value[q] = v;
        tag_seen[q]  = 1'b1;
      end
    end

    if (last) begin
      ok = hdr_bytes[0] == FLAG_BYTE && b == FLAG_BYTE &&
           (hdr_bytes[1] & HI_NIBBLE) == FORMAT_TYPE;
      msize = {hdr_bytes[1][3:0], hdr_bytes[2]};
      for (int q = 0; q < NQ; q++) begin
        r.quantity      = q[4:0];
        r.reading_valid = ok && tag_seen[q];
        r.reading       = 32'h0;
        if (r.reading_valid) begin
          r.reading = tag_value[q];
          if (q < NTOTAL) r.reading = r.reading * 32'd10;
          n_valid++;
        end
        r.list_id      = list_nib;
        r.message_size = msize;
        r.byte_count   = frame_len;
        r.frame_ok     = ok;
        r.last_result  = (q == NQ - 1);
        readings_due.push_back(r);
      end
      n_frames++;
      clear_frame_state();
    end
  endtask

  // Input driver: random gap before each transaction, with gap-free stretches
  bit          tx_busy  = 1'b0;
  bit          tx_burst = 1'b0;
  int          tx_gap   = 0;
  frame_byte_t tx_cur;

  always @(posedge clk) begin
    if (!rst_n) begin
      tx_busy = 1'b0;
      tx_gap  = 0;
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        scan_meter_byte(in_tdata, in_tlast);
        n_bytes++;
        tx_busy = 1'b0;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (bytes_pending.size() > 0) begin
          tx_cur  = bytes_pending.pop_front();
          tx_busy = 1'b1;
          in_tdata <= tx_cur.data;
          in_tlast <= tx_cur.last;
        end
      end
      in_tvalid <= tx_busy;
    end
  end

  // Result monitor: ready held low for a random gap before each transaction
  bit             rx_burst = 1'b0;
  int             rx_gap   = 0;
  meter_reading_t rx_want;
  meter_reading_t rx_got;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_gap = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_got.quantity      = out_tdata[4:0];
        rx_got.reading       = out_tdata[36:5];
        rx_got.reading_valid = out_tdata[37];
        rx_got.list_id       = out_tdata[41:38];
        rx_got.message_size  = out_tdata[53:42];
        rx_got.byte_count    = out_tdata[65:54];
        rx_got.frame_ok      = out_tdata[66];
        rx_got.last_result   = out_tlast;
        if (readings_due.size() == 0) begin
          note_error($sformatf("unexpected result, quantity %0d", rx_got.quantity));
        end else begin
          rx_want = readings_due.pop_front();
          cmp_field("quantity", n_checked, 32'(rx_got.quantity),
                    32'(rx_want.quantity));
          cmp_field("reading", n_checked, rx_got.reading, rx_want.reading);
          cmp_field("reading_valid", n_checked, 32'(rx_got.reading_valid),
                    32'(rx_want.reading_valid));
          cmp_field("list_id", n_checked, 32'(rx_got.list_id),
                    32'(rx_want.list_id));
          cmp_field("message_size", n_checked, 32'(rx_got.message_size),
                    32'(rx_want.message_size));
          cmp_field("byte_count", n_checked, 32'(rx_got.byte_count),
                    32'(rx_want.byte_count));
          cmp_field("frame_ok", n_checked, 32'(rx_got.frame_ok),
                    32'(rx_want.frame_ok));
          cmp_field("last_result", n_checked, 32'(rx_got.last_result),
                    32'(rx_want.last_result));
        end
        n_checked++;
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 15);
      end
      out_tready <= (rx_gap == 0);
      if (rx_gap > 0) rx_gap--;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL obis_meter_frame_value_extractor");
      $finish;
    end
  end

  // Frame building helpers
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_tag(input int q);
    frame_buf.push_back(TAG_STRUCT);
    frame_buf.push_back(TAG_LEN);
    frame_buf.push_back(TAG_A);
    frame_buf.push_back(TAG_B);
    frame_buf.push_back(CODE_C[q]);
    frame_buf.push_back(CODE_D[q]);
    frame_buf.push_back(TAG_E);
    frame_buf.push_back(TAG_F);
  endtask

  task automatic queue_frame();
    frame_byte_t fb;
    for (int i = 0; i < frame_buf.size(); i++) begin
      fb.data = frame_buf[i];
      fb.last = (i == frame_buf.size() - 1);
      bytes_pending.push_back(fb);
    end
    frame_buf.delete();
  endtask

  int q_sweep = 0;

  // Mostly well-formed frames holding tag records, markers and noise
  task automatic build_random_frame();
    int kind;
    int q;
    int len;
    int nseg;
    int hdr_kind;
    hdr_kind = $urandom_range(0, 19);
    nseg = $urandom_range(1, 5);
    if (hdr_kind < 15) begin
      frame_buf.push_back(FLAG_BYTE);
      frame_buf.push_back(FORMAT_TYPE | 8'($urandom_range(0, 15)));
      frame_buf.push_back(rand_byte());
    end else if (hdr_kind < 18) begin
      repeat (3) frame_buf.push_back(rand_byte());
    end else begin
      // short frame: partial header, no body
      repeat ($urandom_range(0, 2)) frame_buf.push_back(rand_byte());
      nseg = 0;
    end

    for (int s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5 || kind == 8) begin
        if ($urandom_range(0, 3) == 0) begin
          q = $urandom_range(0, NQ - 1);
        end else begin
          q = q_sweep;
          q_sweep = (q_sweep + 1) % NQ;
        end
        len = VAL_LONG[q] ? 4 : 2;
        push_tag(q);
        frame_buf.push_back(rand_byte());
        if (kind == 8) begin
          // value cut off by the end of the frame
          repeat ($urandom_range(0, len - 2)) frame_buf.push_back(rand_byte());
          break;
        end
        repeat (len) frame_buf.push_back(rand_byte());
      end else if (kind == 6) begin
        frame_buf.push_back(MARK_0);
        frame_buf.push_back(MARK_1);
        frame_buf.push_back(MARK_2);
        frame_buf.push_back(MARK_3);
        frame_buf.push_back(rand_byte());
        frame_buf.push_back(rand_byte());
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 4)) frame_buf.push_back(rand_byte());
      end else begin
        // tag with one byte corrupted
        q = $urandom_range(0, NQ - 1);
        push_tag(q);
        frame_buf[frame_buf.size() - 1 - $urandom_range(0, 7)] = rand_byte();
        repeat (VAL_LONG[q] ? 5 : 3) frame_buf.push_back(rand_byte());
      end
    end

    frame_buf.push_back(($urandom_range(0, 6) != 0) ? FLAG_BYTE : rand_byte());
    queue_frame();
  endtask

  // Stimulus and end of run
  initial begin
    clear_frame_state();

    // one-byte frame: only the flag byte, the rest of the header reads as zero
    frame_buf.push_back(FLAG_BYTE);
    queue_frame();

    // total energy near the top of its range, wraps when scaled; max message size
    frame_buf.push_back(FLAG_BYTE);
    frame_buf.push_back(FORMAT_TYPE | LO_NIBBLE);
    frame_buf.push_back(8'hFF);
    push_tag(0);
    frame_buf.push_back(8'h06);
    repeat (3) frame_buf.push_back(8'hFF);
    frame_buf.push_back(FLAG_BYTE);
    queue_frame();

    // bad closing flag, date marker cut off before the list byte
    frame_buf.push_back(FLAG_BYTE);
    frame_buf.push_back(8'hA5);
    frame_buf.push_back(8'h12);
    frame_buf.push_back(MARK_0);
    frame_buf.push_back(MARK_1);
    frame_buf.push_back(MARK_2);
    frame_buf.push_back(MARK_3);
    queue_frame();

    // random frames until enough bytes are queued
    begin
      int base;
      base = bytes_pending.size();
      while (bytes_pending.size() - base < RANDOM_BYTES)
        build_random_frame();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_pending.size() != 0 || tx_busy) @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frames (%0d bytes) incl. short and malformed ones;",
             n_frames, n_bytes);
    $display("checked %0d results, %0d of them valid readings.", n_checked, n_valid);
    if (n_errors == 0) begin
      $display("PASS obis_meter_frame_value_extractor");
    end else begin
      $display("FAIL obis_meter_frame_value_extractor");
    end
    $finish;
  end

endmodule

### sim.f
design/obis_pkg.sv
design/obis_scan.sv
design/obis_emit.sv
design/obis_meter_frame_value_extractor.sv
bench/obis_meter_frame_value_extractor_tb.sv
